### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SBR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define SBR_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### design/sbr_pkg.sv
// ---------------------------------------------------------------------------
// sbr_pkg
// Shared sizes, register indexes and helpers of the stack blur block.
// ---------------------------------------------------------------------------
package sbr_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int MAX_RADIUS  = 63;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;
   localparam int COORD_W     = 8;
   localparam int DIM_W       = 9;
   localparam int RAD_W       = 6;
   localparam int TAP_W       = 7;
   localparam int WT_W        = 7;
   localparam int CH_W        = 8;
   localparam int RGB_W       = 24;
   localparam int PIX_W       = 32;
   localparam int SUM_W       = 20;
   localparam int DIVR_W      = 13;
   localparam int DSH_W       = 21;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUR_RADIUS  = 2'd2;

   localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);
   localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(1);

   typedef logic [CH_W-1:0]  chan_type;
   typedef logic [SUM_W-1:0] sum_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_MAX) r = DIM_MAX;
      else r = v;
      return r;
   endfunction

   function automatic logic [RAD_W-1:0] clamp_rad(input logic [RAD_W-1:0] v);
      logic [RAD_W-1:0] r;
      if (v == '0) r = RAD_W'(1);
      else r = v;
      return r;
   endfunction

endpackage

### design/stack_blur_rgb_image.sv
// ---------------------------------------------------------------------------
// stack_blur_rgb_image
// Frame load, two-pass triangle-window blur, raster read-out of ARGB pixels.
// ---------------------------------------------------------------------------
//  channel | ports                              | direction
//  req     | req_valid/ready, func, pixel_in    | in
//  rsp     | rsp_valid/ready, pixel_out, flags  | out
//  csr     | csr_we, csr_addr, csr_wdata        | in
//
// Load: a pixel is stored when its request is taken. Read: from the frame
// store read port, held until rsp_ready. Blur after the last load, per pixel
// and pass: 2R+1 taps (store read, then multiply-accumulate), 8 divide steps,
// ST_ALPHA (second pass only), ST_WRITE. req_ready is low during the blur.
// Synchronous active-high reset clears control; stores are not cleared.
module stack_blur_rgb_image (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [sbr_pkg::PIX_W-1:0]         req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sbr_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic                              rsp_last_pixel,
   output logic                              rsp_image_ready,
   input  logic                              csr_we,
   input  logic [sbr_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [sbr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TAP_RD = 3'd1;
   localparam logic [2:0] ST_TAP_AC = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_ALPHA  = 3'd4;
   localparam logic [2:0] ST_WRITE  = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   localparam int AW = sbr_pkg::ADDR_W;
   localparam int CW = sbr_pkg::COORD_W;

   logic [2:0] state_ff, state_in;
   logic [sbr_pkg::DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [sbr_pkg::RAD_W-1:0] radius_ff, radius_in;
   logic [sbr_pkg::DIM_W-1:0] bw_ff, bw_in, bh_ff, bh_in;
   logic [sbr_pkg::RAD_W-1:0] br_ff, br_in;
   logic [sbr_pkg::DIVR_W-1:0] divr_ff, divr_in;
   logic pass_ff, pass_in;
   logic [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic [sbr_pkg::TAP_W-1:0] tap_ff, tap_in;
   logic [2:0] step_ff, step_in;
   logic [sbr_pkg::DSH_W-1:0] ds_ff, ds_in;
   sbr_pkg::sum_type  acc_ff [3];
   sbr_pkg::sum_type  acc_in [3];
   sbr_pkg::chan_type q_ff [3];
   sbr_pkg::chan_type q_in [3];
   logic [sbr_pkg::COUNT_W-1:0] load_count_ff, load_count_in;
   logic [AW-1:0] read_count_ff, read_count_in;
   logic result_valid_ff, result_valid_in;
   logic rsp_have_ff, rsp_have_in, rsp_last_ff, rsp_last_in;

   logic [sbr_pkg::PIX_W-1:0] frame_mem [sbr_pkg::STORE_DEPTH];
   logic [sbr_pkg::RGB_W-1:0] row_mem [sbr_pkg::STORE_DEPTH];
   logic [sbr_pkg::PIX_W-1:0] frame_q;
   logic [sbr_pkg::RGB_W-1:0] row_q;

   logic req_fire;
   logic [sbr_pkg::DIM_W-1:0] eff_w, eff_h, n_len;
   logic [sbr_pkg::RAD_W-1:0] eff_r;
   logic [sbr_pkg::COUNT_W-1:0] total;
   logic [CW-1:0] along, clamped, rx, ry;
   logic signed [10:0] pos;
   logic [sbr_pkg::COUNT_W-1:0] lin;
   logic [AW-1:0] addr, frame_raddr, frame_waddr;
   logic frame_we, row_we;
   logic [sbr_pkg::PIX_W-1:0] frame_wdata;
   logic signed [7:0] off;
   logic [6:0] mag;
   logic [sbr_pkg::WT_W-1:0] wt;
   logic [sbr_pkg::RGB_W-1:0] tap_rgb;
   logic [sbr_pkg::TAP_W-1:0] rp1;
   logic [sbr_pkg::COUNT_W-1:0] next_load;

   function automatic sbr_pkg::chan_type tap_tap(input logic [sbr_pkg::RGB_W-1:0] rgb,
                                                 input int c);
      sbr_pkg::chan_type v;
      case (c)
         0:       v = rgb[23:16];
         1:       v = rgb[15:8];
         default: v = rgb[7:0];
      endcase
      return v;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign req_fire  = req_valid && req_ready;

   assign eff_w = sbr_pkg::clamp_dim(width_ff);
   assign eff_h = sbr_pkg::clamp_dim(height_ff);
   assign eff_r = sbr_pkg::clamp_rad(radius_ff);
   assign total = sbr_pkg::COUNT_W'(eff_w) * sbr_pkg::COUNT_W'(eff_h);
   assign rp1   = sbr_pkg::TAP_W'(eff_r) + sbr_pkg::TAP_W'(1);

   // window coordinate of the current tap, clamped to the border
   assign n_len = pass_ff ? bh_ff : bw_ff;
   assign along = pass_ff ? y_ff : x_ff;
   assign pos = $signed({3'b000, along}) + $signed({4'b0000, tap_ff})
              - $signed({5'b00000, br_ff});
   always_comb begin
      if (pos < 0) clamped = '0;
      else if (pos >= $signed({2'b00, n_len})) clamped = CW'(n_len - 1'b1);
      else clamped = pos[CW-1:0];
   end
   assign rx = (state_ff == ST_TAP_RD && !pass_ff) ? clamped : x_ff;
   assign ry = (state_ff == ST_TAP_RD &&  pass_ff) ? clamped : y_ff;
   assign lin  = sbr_pkg::COUNT_W'(ry) * sbr_pkg::COUNT_W'(bw_ff) + sbr_pkg::COUNT_W'(rx);
   assign addr = lin[AW-1:0];

   assign off = $signed({1'b0, tap_ff}) - $signed({2'b00, br_ff});
   assign mag = off[7] ? 7'(-off) : off[6:0];
   assign wt  = sbr_pkg::WT_W'(br_ff) + sbr_pkg::WT_W'(1) - mag;
   assign tap_rgb = pass_ff ? row_q : frame_q[sbr_pkg::RGB_W-1:0];

   assign frame_raddr = (state_ff == ST_IDLE) ? read_count_ff : addr;
   assign next_load   = (result_valid_ff ? '0 : load_count_ff);

   always_comb begin
      frame_we    = 1'b0;
      frame_waddr = addr;
      frame_wdata = {frame_q[31:24], q_ff[0], q_ff[1], q_ff[2]};
      if (req_fire && !req_func && next_load < total) begin
         frame_we    = 1'b1;
         frame_waddr = next_load[AW-1:0];
         frame_wdata = req_pixel_in;
      end else if (state_ff == ST_WRITE && pass_ff) begin
         frame_we = 1'b1;
      end
   end
   assign row_we = (state_ff == ST_WRITE) && !pass_ff;

   always_ff @(posedge clock) begin
      if (frame_we) frame_mem[frame_waddr] <= frame_wdata;
      if (state_ff != ST_RESP) frame_q <= frame_mem[frame_raddr];
   end

   always_ff @(posedge clock) begin
      if (row_we) row_mem[addr] <= {q_ff[0], q_ff[1], q_ff[2]};
      row_q <= row_mem[addr];
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      width_in        = width_ff;
      height_in       = height_ff;
      radius_in       = radius_ff;
      bw_in           = bw_ff;
      bh_in           = bh_ff;
      br_in           = br_ff;
      divr_in         = divr_ff;
      pass_in         = pass_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      tap_in          = tap_ff;
      step_in         = step_ff;
      ds_in           = ds_ff;
      acc_in          = acc_ff;
      q_in            = q_ff;
      load_count_in   = load_count_ff;
      read_count_in   = read_count_ff;
      result_valid_in = result_valid_ff;
      rsp_have_in     = rsp_have_ff;
      rsp_last_in     = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_addr)
            sbr_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            sbr_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            sbr_pkg::CSR_BLUR_RADIUS:  radius_in = csr_wdata[sbr_pkg::RAD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !req_func) begin
               if (result_valid_ff) begin
                  result_valid_in = 1'b0;
                  read_count_in   = '0;
               end
               if (next_load + 1'b1 >= total) begin
                  load_count_in = '0;
                  bw_in   = eff_w;
                  bh_in   = eff_h;
                  br_in   = eff_r;
                  divr_in = sbr_pkg::DIVR_W'(rp1) * sbr_pkg::DIVR_W'(rp1);
                  pass_in = 1'b0;
                  x_in    = '0;
                  y_in    = '0;
                  tap_in  = '0;
                  for (int c = 0; c < 3; c++) acc_in[c] = '0;
                  state_in = ST_TAP_RD;
               end else begin
                  load_count_in = next_load + 1'b1;
               end
            end else if (req_fire) begin
               rsp_have_in = result_valid_ff;
               rsp_last_in = 1'b0;
               if (result_valid_ff) begin
                  if (sbr_pkg::COUNT_W'(read_count_ff) + 1'b1 >= total) begin
                     rsp_last_in     = 1'b1;
                     result_valid_in = 1'b0;
                     read_count_in   = '0;
                  end else begin
                     read_count_in = read_count_ff + 1'b1;
                  end
               end
               state_in = ST_RESP;
            end
         end
         ST_TAP_RD: state_in = ST_TAP_AC;
         ST_TAP_AC: begin
            for (int c = 0; c < 3; c++)
               acc_in[c] = acc_ff[c]
                  + sbr_pkg::SUM_W'(tap_tap(tap_rgb, c)) * sbr_pkg::SUM_W'(wt);
            if (tap_ff == sbr_pkg::TAP_W'({br_ff, 1'b0})) begin
               tap_in   = '0;
               step_in  = '0;
               ds_in    = sbr_pkg::DSH_W'(divr_ff) << 7;
               state_in = ST_DIV;
            end else begin
               tap_in   = tap_ff + 1'b1;
               state_in = ST_TAP_RD;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per lane per cycle
            for (int c = 0; c < 3; c++) begin
               if ({1'b0, acc_ff[c]} >= ds_ff) begin
                  acc_in[c] = acc_ff[c] - ds_ff[sbr_pkg::SUM_W-1:0];
                  q_in[c]   = {q_ff[c][6:0], 1'b1};
               end else begin
                  q_in[c]   = {q_ff[c][6:0], 1'b0};
               end
            end
            ds_in   = ds_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd7) state_in = pass_ff ? ST_ALPHA : ST_WRITE;
         end
         ST_ALPHA: state_in = ST_WRITE;
         ST_WRITE: begin
            for (int c = 0; c < 3; c++) acc_in[c] = '0;
            state_in = ST_TAP_RD;
            if (x_ff == CW'(bw_ff - 1'b1)) begin
               x_in = '0;
               if (y_ff == CW'(bh_ff - 1'b1)) begin
                  y_in = '0;
                  if (!pass_ff) begin
                     pass_in = 1'b1;
                  end else begin
                     result_valid_in = 1'b1;
                     read_count_in   = '0;
                     state_in        = ST_IDLE;
                  end
               end else begin
                  y_in = y_ff + 1'b1;
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         width_ff        <= sbr_pkg::DIM_RESET;
         height_ff       <= sbr_pkg::DIM_RESET;
         radius_ff       <= sbr_pkg::RAD_RESET;
         load_count_ff   <= '0;
         read_count_ff   <= '0;
         result_valid_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         radius_ff       <= radius_in;
         load_count_ff   <= load_count_in;
         read_count_ff   <= read_count_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bw_ff       <= bw_in;
      bh_ff       <= bh_in;
      br_ff       <= br_in;
      divr_ff     <= divr_in;
      pass_ff     <= pass_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      tap_ff      <= tap_in;
      step_ff     <= step_in;
      ds_ff       <= ds_in;
      acc_ff      <= acc_in;
      q_ff        <= q_in;
      rsp_have_ff <= rsp_have_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_pixel_out   = rsp_have_ff ? frame_q : '0;
   assign rsp_last_pixel  = rsp_last_ff;
   assign rsp_image_ready = rsp_have_ff;

endmodule

### design/sbr_checker.sv
// ---------------------------------------------------------------------------
// sbr_checker
// Port-level checks of the stack blur block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [sbr_pkg::PIX_W-1:0] rsp_pixel_out,
   input logic                      rsp_last_pixel,
   input logic                      rsp_image_ready
);

   logic                        rsp_stall, rsp_fire, empty_data;
   logic [sbr_pkg::PIX_W+1:0]   rsp_word;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign rsp_word   = {rsp_pixel_out, rsp_last_pixel, rsp_image_ready};
   // a read with no image must come back all zero, with rsp_last_pixel low
   assign empty_data = rsp_valid && !rsp_image_ready && (rsp_pixel_out != '0 || rsp_last_pixel);

   `SBR_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_word), "rsp changed")

   `SBR_ASSERT_NEVER(a_one_at_a_time, clock, reset, req_ready && rsp_valid, "req taken while busy")

   `SBR_ASSERT_NEVER(a_empty_rsp, clock, reset, empty_data, "read without image returned data")

   `SBR_ASSERT(a_rsp_single, clock, reset, rsp_fire |=> !rsp_valid, "response repeated")

endmodule

bind stack_blur_rgb_image sbr_checker u_sbr_checker (.*);
